// ===== src/qte_pkg.sv =====
package qte_pkg;

    localparam int ANGLE_FRAC_BITS = 7;
    localparam int CORDIC_STEPS    = 16;
    localparam int ACC_FRAC        = 24;
    localparam int TABLE_LEN       = 24;
    localparam int NSTEPS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

    // vector width: |v| grows to about 1.65 * 5 * 2^30 at most, with sign
    localparam int VW = 36;
    // angle accumulator, degrees with 24 fraction bits
    localparam int ZW = 36;
    // radicand width for 2^60 - s^2
    localparam int RW = 62;
    localparam int QW = 31;

    typedef logic signed [VW-1:0] t_vec;
    typedef logic signed [ZW-1:0] t_ang;

    function automatic t_ang atan_q24(input int i);
        case (i)
            0:  atan_q24 = 36'sd754974720;
            1:  atan_q24 = 36'sd445687602;
            2:  atan_q24 = 36'sd235489088;
            3:  atan_q24 = 36'sd119537938;
            4:  atan_q24 = 36'sd60000934;
            5:  atan_q24 = 36'sd30029717;
            6:  atan_q24 = 36'sd15018523;
            7:  atan_q24 = 36'sd7509720;
            8:  atan_q24 = 36'sd3754917;
            9:  atan_q24 = 36'sd1877466;
            10: atan_q24 = 36'sd938734;
            11: atan_q24 = 36'sd469367;
            12: atan_q24 = 36'sd234684;
            13: atan_q24 = 36'sd117342;
            14: atan_q24 = 36'sd58671;
            15: atan_q24 = 36'sd29335;
            16: atan_q24 = 36'sd14668;
            17: atan_q24 = 36'sd7334;
            18: atan_q24 = 36'sd3667;
            19: atan_q24 = 36'sd1833;
            20: atan_q24 = 36'sd917;
            21: atan_q24 = 36'sd458;
            22: atan_q24 = 36'sd229;
            default: atan_q24 = 36'sd115;
        endcase
    endfunction

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } t_quat;

    typedef struct packed {
        logic signed [15:0] roll_deg;
        logic signed [14:0] pitch_deg;
        logic signed [15:0] yaw_deg;
        logic               pitch_clamped;
    } t_euler;

endpackage

// ===== src/qte_if.sv =====
interface qte_quat_if;
    logic valid;
    logic ready;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_euler_if;
    logic valid;
    logic ready;
    logic signed [15:0] roll_deg;
    logic signed [14:0] pitch_deg;
    logic signed [15:0] yaw_deg;
    logic               pitch_clamped;
    modport source (output valid, roll_deg, pitch_deg, yaw_deg, pitch_clamped, input ready);
    modport sink   (input valid, roll_deg, pitch_deg, yaw_deg, pitch_clamped, output ready);
endinterface

// ===== src/qte_cordic_step.sv =====
// one registered vectoring micro-rotation, three vectors side by side
module qte_cordic_step (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic [4:0]    i_step,
    input  logic          i_valid,
    input  qte_pkg::t_vec i_x [3],
    input  qte_pkg::t_vec i_y [3],
    input  qte_pkg::t_ang i_z [3],
    output logic          o_valid,
    output qte_pkg::t_vec o_x [3],
    output qte_pkg::t_vec o_y [3],
    output qte_pkg::t_ang o_z [3]
);
    import qte_pkg::*;

    t_vec n_x [3];
    t_vec n_y [3];
    t_ang n_z [3];
    t_ang w_a;

    assign w_a = atan_q24(int'(i_step));

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (!i_y[k][VW-1]) begin
                n_x[k] = i_x[k] + (i_y[k] >>> i_step);
                n_y[k] = i_y[k] - (i_x[k] >>> i_step);
                n_z[k] = i_z[k] + w_a;
            end else begin
                n_x[k] = i_x[k] - (i_y[k] >>> i_step);
                n_y[k] = i_y[k] + (i_x[k] >>> i_step);
                n_z[k] = i_z[k] - w_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
        if (i_en) begin
            o_x <= n_x;
            o_y <= n_y;
            o_z <= n_z;
        end
    end
endmodule

// ===== src/quaternion_to_euler_angles_unit.sv =====
// Quaternion (Q1.15) to Z-Y-X Euler angles in degrees with 7 fraction bits.
// Fully pipelined: one quaternion is accepted every cycle while the output
// register is empty or being taken, and each result passes through 3 front
// stages (the component products, the sin/cos terms, the partial squares of
// the pitch sine), 31 stages of a one-bit-per-stage square root for the pitch
// cosine, 1 pre-rotation stage, 16 CORDIC stages (three vectors in parallel)
// and 1 output stage. The whole pipe advances when the output register is
// empty or being taken, so a stall holds every stage and loses nothing.
// Pitch clamps to +-90 with pitch_clamped set when |2(wy-zx)| reaches one.
module quaternion_to_euler_angles_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    qte_quat_if.sink    i_quat,
    qte_euler_if.source o_euler
);
    import qte_pkg::*;

    logic w_en;
    assign w_en = !o_euler.valid || o_euler.ready;
    assign i_quat.ready = w_en;

    // stage 1: the nine products
    logic signed [31:0] r_p [9];
    logic r_v1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (w_en) r_v1 <= i_quat.valid;
        if (w_en) begin
            r_p[0] <= i_quat.quat_w * i_quat.quat_x;
            r_p[1] <= i_quat.quat_y * i_quat.quat_z;
            r_p[2] <= i_quat.quat_x * i_quat.quat_x;
            r_p[3] <= i_quat.quat_y * i_quat.quat_y;
            r_p[4] <= i_quat.quat_w * i_quat.quat_z;
            r_p[5] <= i_quat.quat_x * i_quat.quat_y;
            r_p[6] <= i_quat.quat_z * i_quat.quat_z;
            r_p[7] <= i_quat.quat_w * i_quat.quat_y;
            r_p[8] <= i_quat.quat_z * i_quat.quat_x;
        end
    end

    // stage 2: sin/cos terms in Q.30
    t_vec r_sr, r_cr, r_sy, r_cy, r_s;
    logic r_v2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else if (w_en) r_v2 <= r_v1;
        if (w_en) begin
            r_sr <= (VW'(r_p[0]) + VW'(r_p[1])) <<< 1;
            r_cr <= (VW'(1) <<< 30) - ((VW'(r_p[2]) + VW'(r_p[3])) <<< 1);
            r_sy <= (VW'(r_p[4]) + VW'(r_p[5])) <<< 1;
            r_cy <= (VW'(1) <<< 30) - ((VW'(r_p[3]) + VW'(r_p[6])) <<< 1);
            r_s  <= (VW'(r_p[7]) - VW'(r_p[8])) <<< 1;
        end
    end

    // s^2 needs a wide product: split into partial products here,
    // summed in front of the first square-root stage
    logic              w_clamp2;
    logic [30:0]       w_sabs;
    assign w_clamp2 = (r_s >= (VW'(1) <<< 30)) || (r_s <= -(VW'(1) <<< 30));
    assign w_sabs   = r_s[VW-1] ? 31'(-r_s) : 31'(r_s);

    // square-root pipeline stage 0 holds partial products of s^2
    logic [31:0] r_pl, r_pm;
    logic [29:0] r_ph;
    t_vec r_q_sr, r_q_cr, r_q_sy, r_q_cy, r_q_s;
    logic r_q_cl, r_q_v;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_q_v <= 1'b0;
        else if (w_en) r_q_v <= r_v2;
        if (w_en) begin
            r_pl <= 32'(w_sabs[15:0]) * 32'(w_sabs[15:0]);
            r_pm <= 32'(w_sabs[15:0]) * 32'(w_sabs[30:16]);
            r_ph <= 30'(w_sabs[30:16]) * 30'(w_sabs[30:16]);
            r_q_sr <= r_sr; r_q_cr <= r_cr; r_q_sy <= r_sy;
            r_q_cy <= r_cy; r_q_s <= r_s;  r_q_cl <= w_clamp2;
        end
    end

    logic [RW-1:0] w_rad;
    logic [63:0]   w_sq;
    assign w_sq  = ({34'd0, r_ph} << 32) + ({32'd0, r_pm} << 17) + {32'd0, r_pl};
    assign w_rad = r_q_cl ? '0 : RW'((64'd1 << 60) - w_sq);

    // restoring square root, one result bit per stage, QW stages
    logic [RW-1:0] r_rem [QW+1];
    logic [QW-1:0] r_root [QW+1];
    t_vec r_a_sr [QW+1], r_a_cr [QW+1], r_a_sy [QW+1], r_a_cy [QW+1], r_a_s [QW+1];
    logic r_a_cl [QW+1];
    logic r_a_v  [QW+1];

    always_comb begin
        r_rem[0] = w_rad; r_root[0] = '0;
        r_a_sr[0] = r_q_sr; r_a_cr[0] = r_q_cr; r_a_sy[0] = r_q_sy;
        r_a_cy[0] = r_q_cy; r_a_s[0] = r_q_s; r_a_cl[0] = r_q_cl; r_a_v[0] = r_q_v;
    end

    for (genvar g = 0; g < QW; g++) begin : g_sqrt
        localparam int B = QW - 1 - g;
        logic [RW:0]   w_trial;
        logic [RW:0]   w_ext;
        // trial subtrahend (2*root + 2^B) * 2^B, root bits held in place
        assign w_ext   = {1'b0, r_rem[g]};
        assign w_trial = ((RW+1)'(r_root[g]) << (B + 1)) | ((RW+1)'(1) << (2 * B));
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_a_v[g+1] <= 1'b0;
            else if (w_en) r_a_v[g+1] <= r_a_v[g];
            if (w_en) begin
                if (w_ext >= w_trial) begin
                    r_rem[g+1]  <= RW'(w_ext - w_trial);
                    r_root[g+1] <= r_root[g] | (QW'(1) << B);
                end else begin
                    r_rem[g+1]  <= r_rem[g];
                    r_root[g+1] <= r_root[g];
                end
                r_a_sr[g+1] <= r_a_sr[g]; r_a_cr[g+1] <= r_a_cr[g];
                r_a_sy[g+1] <= r_a_sy[g]; r_a_cy[g+1] <= r_a_cy[g];
                r_a_s[g+1]  <= r_a_s[g];  r_a_cl[g+1] <= r_a_cl[g];
            end
        end
    end

    // pre-rotation: fold negative cosine, flag zero vectors
    t_vec w_yi [3], w_xi [3];
    t_vec r_x0 [3], r_y0 [3];
    t_ang r_z0 [3];
    logic [2:0] r_zero0;
    logic r_cl0, r_sg0, r_v0;
    assign w_yi[0] = r_a_sr[QW]; assign w_xi[0] = r_a_cr[QW];
    assign w_yi[1] = r_a_s[QW];  assign w_xi[1] = VW'(r_root[QW]);
    assign w_yi[2] = r_a_sy[QW]; assign w_xi[2] = r_a_cy[QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v0 <= 1'b0;
        else if (w_en) r_v0 <= r_a_v[QW];
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_zero0[k] <= (w_xi[k] == '0) && (w_yi[k] == '0);
                if (w_xi[k][VW-1]) begin
                    r_x0[k] <= -w_xi[k];
                    r_y0[k] <= -w_yi[k];
                    r_z0[k] <= w_yi[k][VW-1] ? -(ZW'(180) <<< ACC_FRAC)
                                             :  (ZW'(180) <<< ACC_FRAC);
                end else begin
                    r_x0[k] <= w_xi[k];
                    r_y0[k] <= w_yi[k];
                    r_z0[k] <= '0;
                end
            end
            r_cl0 <= r_a_cl[QW];
            r_sg0 <= r_a_s[QW][VW-1];
        end
    end

    // cordic chain
    t_vec c_x [NSTEPS+1][3];
    t_vec c_y [NSTEPS+1][3];
    t_ang c_z [NSTEPS+1][3];
    logic c_v [NSTEPS+1];
    logic [2:0] r_zero [NSTEPS+1];
    logic r_cl [NSTEPS+1];
    logic r_sg [NSTEPS+1];

    assign c_x[0] = r_x0; assign c_y[0] = r_y0; assign c_z[0] = r_z0;
    assign c_v[0] = r_v0;
    assign r_zero[0] = r_zero0; assign r_cl[0] = r_cl0; assign r_sg[0] = r_sg0;

    for (genvar g = 0; g < NSTEPS; g++) begin : g_cordic
        qte_cordic_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_step  (5'(g)),
            .i_valid (c_v[g]),
            .i_x     (c_x[g]),
            .i_y     (c_y[g]),
            .i_z     (c_z[g]),
            .o_valid (c_v[g+1]),
            .o_x     (c_x[g+1]),
            .o_y     (c_y[g+1]),
            .o_z     (c_z[g+1])
        );
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_zero[g+1] <= r_zero[g];
                r_cl[g+1]   <= r_cl[g];
                r_sg[g+1]   <= r_sg[g];
            end
        end
    end

    // rounding and saturation
    localparam int SH = ACC_FRAC - ANGLE_FRAC_BITS;
    t_ang w_rnd [3];
    t_ang w_sat [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_rnd[k] = (c_z[NSTEPS][k] + (ZW'(1) <<< (SH - 1))) >>> SH;
            if (r_zero[NSTEPS][k]) w_sat[k] = '0;
            else if (w_rnd[k] > (ZW'(180) <<< ANGLE_FRAC_BITS))
                w_sat[k] = ZW'(180) <<< ANGLE_FRAC_BITS;
            else if (w_rnd[k] < -(ZW'(180) <<< ANGLE_FRAC_BITS))
                w_sat[k] = -(ZW'(180) <<< ANGLE_FRAC_BITS);
            else w_sat[k] = w_rnd[k];
        end
    end

    t_ang w_pitch;
    always_comb begin
        if (r_cl[NSTEPS])
            w_pitch = r_sg[NSTEPS] ? -(ZW'(90) <<< ANGLE_FRAC_BITS)
                                   :  (ZW'(90) <<< ANGLE_FRAC_BITS);
        else if (w_sat[1] > (ZW'(90) <<< ANGLE_FRAC_BITS))
            w_pitch = ZW'(90) <<< ANGLE_FRAC_BITS;
        else if (w_sat[1] < -(ZW'(90) <<< ANGLE_FRAC_BITS))
            w_pitch = -(ZW'(90) <<< ANGLE_FRAC_BITS);
        else w_pitch = w_sat[1];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_euler.valid <= 1'b0;
        else if (w_en) o_euler.valid <= c_v[NSTEPS];
        if (w_en) begin
            o_euler.roll_deg      <= w_sat[0][15:0];
            o_euler.pitch_deg     <= w_pitch[14:0];
            o_euler.yaw_deg       <= w_sat[2][15:0];
            o_euler.pitch_clamped <= r_cl[NSTEPS];
        end
    end
endmodule

// ===== tb/qte_tb_if.sv =====
`timescale 1ns / 1ps
// the block's interfaces live in src/qte_if.sv

// ===== tb/quaternion_to_euler_angles_unit_tb.sv =====
`timescale 1ns / 1ps
module quaternion_to_euler_angles_unit_tb;
    import qte_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int N_RANDOM       = 1200;
    localparam int PIPE_LATENCY   = 52;

    // atan(2^-i) in degrees, 24 fraction bits
    localparam longint ATAN_DEG[24] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115};

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #4 i_clk = ~i_clk;

    qte_quat_if  quat_bus ();
    qte_euler_if euler_bus ();

    quaternion_to_euler_angles_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_quat  (quat_bus.sink),
        .o_euler (euler_bus.source)
    );

    t_euler expected_angles[$];
    int     err_count = 0;
    int     idle_cycles = 0;
    int     stall_left = 0;
    bit     no_idle = 1'b0;
    bit     sink_enable = 1'b0;

    // one directed row: quaternion, and a typed-in answer where it is obvious
    typedef struct {
        t_quat  q;
        bit     has_known;
        t_euler known;
    } t_row;

    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint isqrt(longint unsigned v);
        longint unsigned res = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint clip(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // vectoring cordic, result in output degrees saturated to +-180
    function automatic longint angle_deg(longint sn, longint cs);
        longint acc = 0;
        longint dx, dy;
        if (sn == 0 && cs == 0) return 0;
        if (cs < 0) begin
            // turn by 180 first; zero sine counts as positive
            acc = (sn >= 0) ? (longint'(180) << ACC_FRAC) : -(longint'(180) << ACC_FRAC);
            cs = -cs;
            sn = -sn;
        end
        for (int i = 0; i < NSTEPS; i++) begin
            dx = fshr(sn, i);
            dy = fshr(cs, i);
            if (sn >= 0) begin
                cs += dx; sn -= dy; acc += ATAN_DEG[i];
            end else begin
                cs -= dx; sn += dy; acc -= ATAN_DEG[i];
            end
        end
        acc += longint'(1) << (ACC_FRAC - ANGLE_FRAC_BITS - 1);
        return clip(fshr(acc, ACC_FRAC - ANGLE_FRAC_BITS),
                    longint'(180) << ANGLE_FRAC_BITS);
    endfunction

    function automatic t_euler euler_of(t_quat q);
        longint w = q.quat_w, x = q.quat_x, y = q.quat_y, z = q.quat_z;
        longint one = longint'(1) << 30;
        longint s = 2 * (w * y - z * x);
        longint lim90 = longint'(90) << ANGLE_FRAC_BITS;
        longint p;
        t_euler e;
        e.roll_deg = 16'(angle_deg(2 * (w * x + y * z), one - 2 * (x * x + y * y)));
        e.yaw_deg  = 16'(angle_deg(2 * (w * z + x * y), one - 2 * (y * y + z * z)));
        if (s >= one || s <= -one) begin
            p = (s > 0) ? lim90 : -lim90;
            e.pitch_clamped = 1'b1;
        end else begin
            p = clip(angle_deg(s, isqrt((64'd1 << 60) - longint'(s * s))), lim90);
            e.pitch_clamped = 1'b0;
        end
        e.pitch_deg = 15'(p);
        return e;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        err_count++;
    endtask

    function automatic t_quat rand_quat();
        t_quat q;
        case ($urandom_range(0, 3))
            0: q = t_quat'({$urandom, $urandom});
            // quaternions with every component in -23170..23170
            1: begin
                q.quat_w = 16'($urandom_range(0, 46340)) - 16'sd23170;
                q.quat_x = 16'($urandom_range(0, 46340)) - 16'sd23170;
                q.quat_y = 16'($urandom_range(0, 46340)) - 16'sd23170;
                q.quat_z = 16'($urandom_range(0, 46340)) - 16'sd23170;
            end
            // near the pole: w and |y| large and about equal, x and z small
            2: begin
                q.quat_w = 16'sd23170 + 16'($urandom_range(0, 40)) - 16'sd20;
                q.quat_y = ($urandom_range(0, 1) ? 16'sd23170 : -16'sd23170)
                           + 16'($urandom_range(0, 40)) - 16'sd20;
                q.quat_x = 16'($urandom_range(0, 60)) - 16'sd30;
                q.quat_z = 16'($urandom_range(0, 60)) - 16'sd30;
            end
            default: begin
                q = t_quat'({$urandom, $urandom});
                q.quat_x = 16'(q.quat_x >>> $urandom_range(0, 15));
                q.quat_z = 16'(q.quat_z >>> $urandom_range(0, 15));
            end
        endcase
        return q;
    endfunction

    // send one word, with random idle bursts before it
    task automatic send_quat(t_quat q);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            quat_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        quat_bus.valid  <= 1'b1;
        quat_bus.quat_w <= q.quat_w;
        quat_bus.quat_x <= q.quat_x;
        quat_bus.quat_y <= q.quat_y;
        quat_bus.quat_z <= q.quat_z;
        @(posedge i_clk);
        while (!quat_bus.ready) @(posedge i_clk);
    endtask

    function automatic t_row mk(int w, int x, int y, int z, bit k = 0,
                                int r = 0, int p = 0, int yw = 0, bit c = 0);
        t_row row;
        row.q = '{16'(w), 16'(x), 16'(y), 16'(z)};
        row.has_known = k;
        row.known = '{16'(r), 15'(p), 16'(yw), c};
        return row;
    endfunction

    t_row directed[$];

    // sink: random stall bursts; compare each result against the oldest expectation
    always @(posedge i_clk) begin
        t_euler want;
        if (i_rst_n && euler_bus.valid && euler_bus.ready) begin
            if (expected_angles.size() == 0) begin
                $display("unexpected result word");
                err_count++;
            end else begin
                want = expected_angles.pop_front();
                if (euler_bus.roll_deg !== want.roll_deg)
                    report_mismatch("roll", euler_bus.roll_deg, want.roll_deg);
                if (euler_bus.pitch_deg !== want.pitch_deg)
                    report_mismatch("pitch", euler_bus.pitch_deg, want.pitch_deg);
                if (euler_bus.yaw_deg !== want.yaw_deg)
                    report_mismatch("yaw", euler_bus.yaw_deg, want.yaw_deg);
                if (euler_bus.pitch_clamped !== want.pitch_clamped)
                    report_mismatch("clamp", euler_bus.pitch_clamped, want.pitch_clamped);
            end
        end
        if (!sink_enable) begin
            euler_bus.ready <= 1'b0;
        end else if (no_idle) begin
            euler_bus.ready <= 1'b1;
        end else if (stall_left > 0) begin
            euler_bus.ready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 5) == 0) begin
            // start a stall burst
            euler_bus.ready <= 1'b0;
            stall_left = $urandom_range(0, 2);
        end else begin
            euler_bus.ready <= 1'b1;
        end
    end

    // watchdog: cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((quat_bus.valid && quat_bus.ready) || (euler_bus.valid && euler_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        t_quat q;
        int wait_cycles;
        quat_bus.valid = 1'b0;
        quat_bus.quat_w = '0; quat_bus.quat_x = '0;
        quat_bus.quat_y = '0; quat_bus.quat_z = '0;

        // identity, axis rotations, extremes, zero vector, pole cases
        directed = {directed, mk(32767, 0, 0, 0, 1, 0, 0, 0, 0)};
        directed = {directed, mk(0, 0, 0, 0)};
        directed = {directed, mk(0, 32767, 0, 0)};          // cosine negative, zero sine
        directed = {directed, mk(0, 0, 0, 32767)};
        directed = {directed, mk(0, 0, 32767, 0)};
        directed = {directed, mk(23170, 23170, 0, 0)};      // roll 90
        directed = {directed, mk(23170, 0, 0, 23170)};      // yaw 90
        // pole +, both cosines slightly negative so roll and yaw fold to 180
        directed = {directed, mk(23171, 0, 23171, 0, 1, 23040, 11520, 23040, 1)};
        // pole -
        directed = {directed, mk(23171, 0, -23171, 0, 1, 23040, -11520, 23040, 1)};
        directed = {directed, mk(23170, 0, 23170, 0)};      // just below the pole
        directed = {directed, mk(-32768, -32768, -32768, -32768)};
        directed = {directed, mk(32767, 32767, 32767, 32767)};
        directed = {directed, mk(-32768, 0, 0, 0)};
        directed = {directed, mk(32767, -32768, 32767, -32768)};
        directed = {directed, mk(0, -32768, 0, 1)};         // cosine negative, zero sine
        directed = {directed, mk(16384, 16384, 16384, -16384)};
        directed = {directed, mk(16384, -16384, 16384, 16384)};
        directed = {directed, mk(1, -1, 1, -1)};
        directed = {directed, mk(-1, 1, -1, 1)};
        directed = {directed, mk(23169, 1, 23169, -1)};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        sink_enable <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            expected_angles = {expected_angles,
                               directed[i].has_known ? directed[i].known
                                                     : euler_of(directed[i].q)};
            send_quat(directed[i].q);
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - 200) no_idle = 1'b1;
            q = rand_quat();
            expected_angles = {expected_angles, euler_of(q)};
            send_quat(q);
        end
        quat_bus.valid <= 1'b0;

        wait_cycles = 0;
        while (expected_angles.size() != 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (PIPE_LATENCY + 10) @(posedge i_clk);
        if (err_count == 0 && expected_angles.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// ===== quaternion_to_euler_angles_unit.f =====
src/qte_pkg.sv
src/qte_if.sv
src/qte_cordic_step.sv
src/quaternion_to_euler_angles_unit.sv
tb/qte_tb_if.sv
tb/quaternion_to_euler_angles_unit_tb.sv
